@@ hdl/wts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wts_pkg;

    // quotient bits kept by the divider; ratios are capped at 2^40
    localparam int QUOT_BITS = 41;
    localparam logic [QUOT_BITS-1:0] RATIO_CAP = QUOT_BITS'(1) << (QUOT_BITS - 1);

    // config register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // input func codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    // one queued projection request: the point and matrix rows 0, 1 and 3
    typedef struct packed {
        logic signed [31:0]  px;
        logic signed [31:0]  py;
        logic signed [31:0]  pz;
        logic [11:0][31:0]   mrow;
    } wts_job_t;

endpackage
`default_nettype wire

@@ hdl/world_to_screen_projection.sv @@
`default_nettype none
// A projection result passes the queue, products, clip rows, 43 divider stages,
// scaling and the output register; a stalled output holds the back-end pipeline.
// Throughput: one request per cycle while the output is not stalled, set by the
// one-bit-per-stage divider pipeline. Matrix writes give no result.
// Reset (aresetn low, synchronous): matrix cleared, window 1920x1080, pipeline empty.
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects world points to screen pixels through a stored 4x4 matrix.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [13:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [3:0]         s_entry_index,
    input  wire logic signed [31:0] s_entry_value,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_visible,
    output logic signed [31:0]      m_pixel_x,
    output logic signed [31:0]      m_pixel_y
);
    logic              push, push_ready;
    logic              job_valid, job_ready;
    wts_pkg::wts_job_t push_job, pop_job;

    wts_front u_front (
        .clk           (aclk),
        .rstn          (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .push          (push),
        .push_ready    (push_ready),
        .job           (push_job)
    );

    wts_fifo u_fifo (
        .clk        (aclk),
        .rstn       (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_data   (pop_job)
    );

    wts_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (aclk),
        .rstn      (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_visible (m_visible),
        .m_pixel_x (m_pixel_x),
        .m_pixel_y (m_pixel_y)
    );

endmodule
`default_nettype wire

@@ hdl/wts_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_fifo
// Two-entry queue of projection requests between front and back.
// ----------------------------------------------------------------------------
module wts_fifo (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire logic             push,
    output logic                  push_ready,
    input  wire wts_pkg::wts_job_t push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output wts_pkg::wts_job_t     pop_data
);
    wts_pkg::wts_job_t mem_reg [2];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/wts_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_front
// Accepts input requests, applies matrix writes, queues projections.
// ----------------------------------------------------------------------------
module wts_front (
    input  wire logic               clk,
    input  wire logic               rstn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [3:0]         s_entry_index,
    input  wire logic signed [31:0] s_entry_value,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    output logic                    push,
    input  wire logic               push_ready,
    output wts_pkg::wts_job_t       job
);
    logic [15:0][31:0] mat_reg;
    logic              accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_func == wts_pkg::FUNC_PROJECT);

    always_comb begin
        job.px = s_point_x;
        job.py = s_point_y;
        job.pz = s_point_z;
        for (int k = 0; k < 4; k++) begin
            job.mrow[k]     = mat_reg[k];
            job.mrow[4 + k] = mat_reg[4 + k];
            job.mrow[8 + k] = mat_reg[12 + k];
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            mat_reg <= '0;
        end else if (accept && (s_func == wts_pkg::FUNC_WRITE)) begin
            mat_reg[s_entry_index] <= s_entry_value;
        end
    end

endmodule
`default_nettype wire

@@ hdl/wts_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_div
// Pipelined restoring divider, one quotient bit per stage, two lanes (x, y)
// sharing the clip w divisor. Also forms the visibility test.
// ----------------------------------------------------------------------------
module wts_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rstn,
    input  wire logic                                  en,
    input  wire logic                                  in_vld,
    input  wire logic signed [66-FRAC_BITS:0]          in_cx,
    input  wire logic signed [66-FRAC_BITS:0]          in_cy,
    input  wire logic signed [66-FRAC_BITS:0]          in_cw,
    output logic                                       out_vld,
    output logic                                       out_vis,
    output logic signed [wts_pkg::QUOT_BITS:0]         out_nx,
    output logic signed [wts_pkg::QUOT_BITS:0]         out_ny
);
    localparam int CW = 67 - FRAC_BITS;
    localparam int QB = wts_pkg::QUOT_BITS;
    localparam int SH = QB - FRAC_BITS;
    localparam logic signed [CW-1:0] THRESH = CW'(((1 << FRAC_BITS) + 5) / 10);

    logic          vld_reg [QB+1];
    logic          vis_reg [QB+1];
    logic [CW-1:0] den_reg [QB+1];
    logic [CW-1:0] rem_reg [2][QB+1];
    logic [QB-1:0] low_reg [2][QB+1];
    logic [QB-1:0] quo_reg [2][QB+1];
    logic          neg_reg [2][QB+1];
    logic          ovf_reg [2][QB+1];

    logic signed [CW-1:0] num [2];
    logic [CW-1:0]        mag [2];
    logic [CW-1:0]        den;

    logic                     vld_out_reg, vis_out_reg;
    logic signed [QB:0]       nq_reg [2];

    assign num[0] = in_cx;
    assign num[1] = in_cy;
    assign den    = in_cw;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int k = 0; k <= QB; k++) begin
                vld_reg[k] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= QB; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vld_out_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            vis_reg[0] <= (in_cw >= THRESH);
            den_reg[0] <= den;
            for (int k = 1; k <= QB; k++) begin
                vis_reg[k] <= vis_reg[k-1];
                den_reg[k] <= den_reg[k-1];
            end
            vis_out_reg <= vis_reg[QB];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [CW+SH-1:0]  mag_w;
        logic [CW+SH-1:0]  den_w;
        logic [CW+FRAC_BITS-1:0] dividend;
        logic [QB-1:0]     qf;

        assign mag[l]   = num[l][CW-1] ? (CW'(0) - CW'(num[l])) : CW'(num[l]);
        assign mag_w    = {{SH{1'b0}}, mag[l]};
        assign den_w    = {den, {SH{1'b0}}};
        assign dividend = {mag[l], {FRAC_BITS{1'b0}}};

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[l][0] <= mag[l] >> SH;
                low_reg[l][0] <= dividend[QB-1:0];
                quo_reg[l][0] <= '0;
                neg_reg[l][0] <= num[l][CW-1];
                ovf_reg[l][0] <= (mag_w >= den_w);
            end
        end

        for (genvar k = 1; k <= QB; k++) begin : g_stage
            logic [CW:0] trial;
            logic        ge;

            assign trial = {rem_reg[l][k-1], low_reg[l][k-1][QB-1]};
            assign ge    = (trial >= {1'b0, den_reg[k-1]});

            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[l][k] <= ge ? CW'(trial - {1'b0, den_reg[k-1]}) : trial[CW-1:0];
                    low_reg[l][k] <= {low_reg[l][k-1][QB-2:0], 1'b0};
                    quo_reg[l][k] <= {quo_reg[l][k-1][QB-2:0], ge};
                    neg_reg[l][k] <= neg_reg[l][k-1];
                    ovf_reg[l][k] <= ovf_reg[l][k-1];
                end
            end
        end

        // overflow or quotient above the cap both clamp to 2^40
        assign qf = (ovf_reg[l][QB] || (quo_reg[l][QB] > wts_pkg::RATIO_CAP))
                  ? wts_pkg::RATIO_CAP : quo_reg[l][QB];

        always_ff @(posedge clk) begin
            if (en) begin
                nq_reg[l] <= neg_reg[l][QB] ? ((QB+1)'(0) - {1'b0, qf}) : {1'b0, qf};
            end
        end
    end

    assign out_vld = vld_out_reg;
    assign out_vis = vis_out_reg;
    assign out_nx  = nq_reg[0];
    assign out_ny  = nq_reg[1];

endmodule
`default_nettype wire

@@ hdl/wts_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_back
// Projection pipeline: matrix products, clip rows, divide, pixel mapping.
// The whole pipeline holds while the output register is full and stalled.
// ----------------------------------------------------------------------------
module wts_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rstn,
    input  wire logic               cfg_wen,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [13:0]        cfg_data,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire wts_pkg::wts_job_t  job,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_visible,
    output logic signed [31:0]      m_pixel_x,
    output logic signed [31:0]      m_pixel_y
);
    localparam int CW = 67 - FRAC_BITS;
    localparam int QB = wts_pkg::QUOT_BITS;
    localparam logic signed [QB+1:0] ONE = (QB+2)'(1) << FRAC_BITS;
    localparam logic signed [57:0] SMAX = 58'sd2147483647;
    localparam logic signed [57:0] SMIN = -58'sd2147483648;

    logic [13:0] width_reg, height_reg;
    logic        en;

    logic                 v1_reg;
    logic signed [63:0]   prod_reg [3][3];
    logic signed [31:0]   off_reg  [3];

    logic                 v2_reg;
    logic signed [CW-1:0] clip_reg [3];
    logic signed [CW-1:0] clip_next [3];

    logic                 dv, dvis;
    logic signed [QB:0]   nx, ny;

    logic                 v3_reg, vis3_reg;
    logic signed [57:0]   sx_reg, sy_reg;
    logic signed [57:0]   hx, hy;

    logic                 m_valid_reg, m_visible_reg;
    logic signed [31:0]   m_pixel_x_reg, m_pixel_y_reg;

    assign en        = !m_valid_reg || m_ready;
    assign job_ready = en;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            width_reg  <= 14'd1920;
            height_reg <= 14'd1080;
        end else if (cfg_wen) begin
            if (cfg_index == wts_pkg::CFG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == wts_pkg::CFG_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    // stage 1: nine products
    always_ff @(posedge clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= job.px * $signed(job.mrow[4*r]);
                prod_reg[r][1] <= job.py * $signed(job.mrow[4*r + 1]);
                prod_reg[r][2] <= job.pz * $signed(job.mrow[4*r + 2]);
                off_reg[r]     <= job.mrow[4*r + 3];
            end
        end
    end

    // stage 2: clip rows; floor of the exact sum equals the sum of split parts
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            logic signed [65:0] sum;
            logic signed [65:0] shf;
            sum = {{2{prod_reg[r][0][63]}}, prod_reg[r][0]}
                + {{2{prod_reg[r][1][63]}}, prod_reg[r][1]}
                + {{2{prod_reg[r][2][63]}}, prod_reg[r][2]};
            shf = sum >>> FRAC_BITS;
            clip_next[r] = shf[CW-1:0] + {{(CW-32){off_reg[r][31]}}, off_reg[r]};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                clip_reg[r] <= clip_next[r];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= job_valid;
            v2_reg <= v1_reg;
        end
    end

    wts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rstn    (rstn),
        .en      (en),
        .in_vld  (v2_reg),
        .in_cx   (clip_reg[0]),
        .in_cy   (clip_reg[1]),
        .in_cw   (clip_reg[2]),
        .out_vld (dv),
        .out_vis (dvis),
        .out_nx  (nx),
        .out_ny  (ny)
    );

    // stage: scale by window size
    always_ff @(posedge clk) begin
        if (en) begin
            sx_reg   <= ($signed({nx[QB], nx}) + ONE) * $signed({1'b0, width_reg});
            sy_reg   <= (ONE - $signed({ny[QB], ny})) * $signed({1'b0, height_reg});
            vis3_reg <= dvis;
        end
    end

    assign hx = sx_reg >>> 1;
    assign hy = sy_reg >>> 1;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v3_reg      <= dv;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            m_visible_reg <= vis3_reg;
            if (!vis3_reg) begin
                m_pixel_x_reg <= '0;
                m_pixel_y_reg <= '0;
            end else begin
                m_pixel_x_reg <= (hx > SMAX) ? SMAX[31:0] : (hx < SMIN) ? SMIN[31:0] : hx[31:0];
                m_pixel_y_reg <= (hy > SMAX) ? SMAX[31:0] : (hy < SMIN) ? SMIN[31:0] : hy[31:0];
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_visible = m_visible_reg;
    assign m_pixel_x = m_pixel_x_reg;
    assign m_pixel_y = m_pixel_y_reg;

`ifndef SYNTH
    a_invisible_zero: assert property (@(posedge clk) disable iff (!rstn)
        (m_valid && !m_visible) |-> (m_pixel_x == 32'sd0 && m_pixel_y == 32'sd0))
        else $error("invisible result with nonzero pixels");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rstn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
                                   && $stable(v3_reg)))
        else $error("pipeline moved during stall");

    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rstn)
        (m_valid && !m_ready) |-> !job_ready)
        else $error("request taken while output stalled");
`endif

endmodule
`default_nettype wire
